// ----- hw/rtl/cbad_pkg.sv -----
// shared types and constants for the cpu bus address decoder
`default_nettype none

package cbad_pkg;

  // memory map sizes
  localparam int RamDepth     = 2048;
  localparam int WorkRamDepth = 8192;
  localparam int RomPageDepth = 16384;
  localparam int RomDepth     = 2 * RomPageDepth;

  // request operation codes
  localparam logic [2:0] OP_READ        = 3'd0;
  localparam logic [2:0] OP_PEEK        = 3'd1;
  localparam logic [2:0] OP_WRITE       = 3'd2;
  localparam logic [2:0] OP_STATUS_LOAD = 3'd3;
  localparam logic [2:0] OP_ROM_LOAD    = 3'd4;

  // 8 KB regions selected by address bits 15:13
  localparam logic [2:0] REGION_IRAM = 3'd0;
  localparam logic [2:0] REGION_PPU  = 3'd1;
  localparam logic [2:0] REGION_IO   = 3'd2;
  localparam logic [2:0] REGION_WRAM = 3'd3;

  // ppu register offsets within the 8-byte mirror
  localparam logic [2:0] PPU_REG_CTRL = 3'd0;
  localparam logic [2:0] PPU_REG_ADDR = 3'd6;

  // status register and control field constants
  localparam logic [15:0] STATUS_ADDR       = 16'h2002;
  localparam logic [7:0]  STATUS_CLEAR_MASK = 8'h7F;
  localparam logic [7:0]  CTRL_RESERVED     = 8'hE8;

  // request payload
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } req_t;

  // response payload
  typedef struct packed {
    logic [7:0]  read_data;
    logic        bus_error;
    logic [13:0] vram_address;
    logic [1:0]  nametable_select;
    logic        pattern_select;
    logic        increment_32;
  } rsp_t;

  // source of the read byte for a request in flight
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_IRAM,
    SRC_WRAM,
    SRC_ROM,
    SRC_STATUS
  } src_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cpu_bus_address_decoder_top.sv -----
// cpu bus address decoder: internal ram, work ram, program rom and ppu registers
// a request is captured by the memory read register and lookup stage when accepted, then by
// the response register; one request per cycle unless rsp_stall or the clearing pass holds
// it off; the memory read and response registers form a two-stage pipeline behind the
// synchronous memory ports; reset clears the ppu registers and the mirror setting at once,
// then a clearing pass zeroes both rams while req_stall is high
`default_nettype none

module cpu_bus_address_decoder_top #(
  parameter int WORK_RAM_DEPTH = cbad_pkg::WorkRamDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire cbad_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output cbad_pkg::rsp_t       rsp,
  input  wire logic            cfg_write_enable,
  input  wire logic            cfg_write_data
);

  localparam int IramAw   = $clog2(cbad_pkg::RamDepth);
  localparam int WramAw   = $clog2(WORK_RAM_DEPTH);
  localparam int RomAw    = $clog2(cbad_pkg::RomDepth);
  localparam int ClrDepth = (cbad_pkg::RamDepth > WORK_RAM_DEPTH) ?
                            cbad_pkg::RamDepth : WORK_RAM_DEPTH;
  localparam int ClrAw    = $clog2(ClrDepth);

  // work ram window offset folded onto the ram depth (at most seven wraps)
  function automatic logic [WramAw-1:0] wram_index(input logic [12:0] off);
    logic [12:0] base;
    base = '0;
    for (int k = 1; k <= 7; k++) begin
      if (int'(off) >= k * WORK_RAM_DEPTH) begin
        base = 13'(k * WORK_RAM_DEPTH);
      end
    end
    return WramAw'(off - base);
  endfunction

  // storage
  logic [7:0] iram [cbad_pkg::RamDepth];
  logic [7:0] wram [WORK_RAM_DEPTH];
  logic [7:0] rom  [cbad_pkg::RomDepth];
  logic [7:0] iram_q;
  logic [7:0] wram_q;
  logic [7:0] rom_q;

  // control and ppu registers
  logic             clearing;
  logic [ClrAw-1:0] clr_cnt;
  logic             rom_half_mirror;
  logic [7:0]       ppu_status;
  logic [13:0]      ppu_addr_latch;
  logic             low_byte_next;
  logic [1:0]       nametable_reg;
  logic             pattern_reg;
  logic             step32_reg;

  // lookup stage
  logic                s1_valid;
  cbad_pkg::src_t      s1_src;
  logic [7:0]          s1_status;
  logic                s1_error;

  // decode results
  logic                req_accept;
  logic                s1_advance;
  logic [2:0]          region;
  cbad_pkg::src_t      src;
  logic                error;
  logic [7:0]          ppu_status_next;
  logic [13:0]         ppu_addr_latch_next;
  logic                low_byte_next_next;
  logic [1:0]          nametable_reg_next;
  logic                pattern_reg_next;
  logic                step32_reg_next;
  logic                iram_we;
  logic                wram_we;
  logic                rom_we;
  logic [IramAw-1:0]   iram_addr;
  logic [WramAw-1:0]   wram_addr;
  logic [RomAw-1:0]    rom_rd_addr;
  logic [7:0]          read_byte;

  // handshake
  assign s1_advance = s1_valid && !(rsp_valid && rsp_stall);
  assign req_stall  = clearing || (s1_valid && !s1_advance);
  assign req_accept = req_valid && !req_stall;

  // memory addresses
  assign region      = req.bus_address[15:13];
  assign iram_addr   = clearing ? clr_cnt[IramAw-1:0] : req.bus_address[IramAw-1:0];
  assign wram_addr   = clearing ? clr_cnt[WramAw-1:0] : wram_index(req.bus_address[12:0]);
  assign rom_rd_addr = {req.bus_address[14] & !rom_half_mirror, req.bus_address[13:0]};

  // request decode and next register values
  always_comb begin
    src                 = cbad_pkg::SRC_NONE;
    error               = 1'b0;
    ppu_status_next     = ppu_status;
    ppu_addr_latch_next = ppu_addr_latch;
    low_byte_next_next  = low_byte_next;
    nametable_reg_next  = nametable_reg;
    pattern_reg_next    = pattern_reg;
    step32_reg_next     = step32_reg;
    iram_we             = 1'b0;
    wram_we             = 1'b0;
    rom_we              = 1'b0;
    case (req.opcode)
      cbad_pkg::OP_READ, cbad_pkg::OP_PEEK: begin
        if (req.opcode == cbad_pkg::OP_READ && req.bus_address == cbad_pkg::STATUS_ADDR) begin
          src             = cbad_pkg::SRC_STATUS;
          ppu_status_next = ppu_status & cbad_pkg::STATUS_CLEAR_MASK;
        end else if (region == cbad_pkg::REGION_IRAM) begin
          src = cbad_pkg::SRC_IRAM;
        end else if (region == cbad_pkg::REGION_WRAM) begin
          src = cbad_pkg::SRC_WRAM;
        end else if (req.bus_address[15]) begin
          src = cbad_pkg::SRC_ROM;
        end else begin
          error = 1'b1;
        end
      end
      cbad_pkg::OP_WRITE: begin
        if (region == cbad_pkg::REGION_IRAM) begin
          iram_we = 1'b1;
        end else if (region == cbad_pkg::REGION_PPU) begin
          case (req.bus_address[2:0])
            cbad_pkg::PPU_REG_CTRL: begin
              nametable_reg_next = req.bus_data[1:0];
              pattern_reg_next   = req.bus_data[4];
              step32_reg_next    = req.bus_data[2];
              error              = |(req.bus_data & cbad_pkg::CTRL_RESERVED);
            end
            cbad_pkg::PPU_REG_ADDR: begin
              if (low_byte_next) begin
                ppu_addr_latch_next = {ppu_addr_latch[13:8], req.bus_data};
              end else begin
                ppu_addr_latch_next = {req.bus_data[5:0], ppu_addr_latch[7:0]};
              end
              low_byte_next_next = !low_byte_next;
            end
            default: begin
              error = 1'b1;
            end
          endcase
        end else if (region == cbad_pkg::REGION_IO) begin
          error = 1'b1;
        end else if (region == cbad_pkg::REGION_WRAM) begin
          wram_we = 1'b1;
        end
      end
      cbad_pkg::OP_STATUS_LOAD: begin
        ppu_status_next = req.bus_data;
      end
      cbad_pkg::OP_ROM_LOAD: begin
        if (req.bus_address[15]) begin
          error = 1'b1;
        end else begin
          rom_we = 1'b1;
        end
      end
      default: begin
        error = 1'b1;
      end
    endcase
  end

  // internal ram, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if ((clearing && int'(clr_cnt) < cbad_pkg::RamDepth) || (req_accept && iram_we)) begin
      iram[iram_addr] <= clearing ? 8'h00 : req.bus_data;
    end
    if (req_accept) begin
      iram_q <= iram[iram_addr];
    end
  end

  // work ram, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if ((clearing && int'(clr_cnt) < WORK_RAM_DEPTH) || (req_accept && wram_we)) begin
      wram[wram_addr] <= clearing ? 8'h00 : req.bus_data;
    end
    if (req_accept) begin
      wram_q <= wram[wram_addr];
    end
  end

  // program rom, loaded one byte per request
  always_ff @(posedge clk) begin
    if (req_accept && rom_we) begin
      rom[req.bus_address[RomAw-1:0]] <= req.bus_data;
    end
    if (req_accept) begin
      rom_q <= rom[rom_rd_addr];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == ClrAw'(ClrDepth - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // mirror setting
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_half_mirror <= 1'b0;
    end else if (cfg_write_enable) begin
      rom_half_mirror <= cfg_write_data;
    end
  end

  // ppu registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ppu_status     <= '0;
      ppu_addr_latch <= '0;
      low_byte_next  <= 1'b0;
      nametable_reg  <= '0;
      pattern_reg    <= 1'b0;
      step32_reg     <= 1'b0;
    end else if (req_accept) begin
      ppu_status     <= ppu_status_next;
      ppu_addr_latch <= ppu_addr_latch_next;
      low_byte_next  <= low_byte_next_next;
      nametable_reg  <= nametable_reg_next;
      pattern_reg    <= pattern_reg_next;
      step32_reg     <= step32_reg_next;
    end
  end

  // lookup stage: remembers where the byte comes from
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_src    <= src;
      s1_status <= ppu_status;
      s1_error  <= error;
    end
  end

  // read byte select
  always_comb begin
    case (s1_src)
      cbad_pkg::SRC_IRAM:   read_byte = iram_q;
      cbad_pkg::SRC_WRAM:   read_byte = wram_q;
      cbad_pkg::SRC_ROM:    read_byte = rom_q;
      cbad_pkg::SRC_STATUS: read_byte = s1_status;
      default:              read_byte = 8'h00;
    endcase
  end

  // response register; ppu fields carry the values after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp.read_data        <= read_byte;
      rsp.bus_error        <= s1_error;
      rsp.vram_address     <= ppu_addr_latch;
      rsp.nametable_select <= nametable_reg;
      rsp.pattern_select   <= pattern_reg;
      rsp.increment_32     <= step32_reg;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/cbad_tb_pkg.sv -----
// scoreboard that predicts cpu bus decoder responses from accepted requests
package cbad_tb_pkg;

  localparam logic [15:0] WRAM_BASE = 16'h6000;

  class bus_map_scoreboard;
    // shadow copy of the decoder state
    logic [7:0]  iram [cbad_pkg::RamDepth];
    logic [7:0]  wram [cbad_pkg::WorkRamDepth];
    logic [7:0]  rom [cbad_pkg::RomDepth];
    bit          rom_loaded [cbad_pkg::RomDepth];
    logic [7:0]  status;
    logic [13:0] vaddr;
    logic        low_next;
    logic [1:0]  nametable;
    logic        pattern;
    logic        step32;
    logic        half_mirror;
    cbad_pkg::rsp_t predicted_rsp [$];
    int          mismatches;

    function new();
      foreach (iram[i]) iram[i] = '0;
      foreach (wram[i]) wram[i] = '0;
      foreach (rom[i]) begin
        rom[i] = '0;
        rom_loaded[i] = 1'b0;
      end
      status = '0;
      vaddr = '0;
      low_next = 1'b0;
      nametable = '0;
      pattern = 1'b0;
      step32 = 1'b0;
      half_mirror = 1'b0;
      mismatches = 0;
    endfunction

    // image offset for an address at 0x8000 and up
    function logic [14:0] rom_offset(logic [15:0] a);
      return {a[14] & !half_mirror, a[13:0]};
    endfunction

    // true unless the address lands on an image byte never loaded
    function bit rom_readable(logic [15:0] a);
      return !a[15] || rom_loaded[rom_offset(a)];
    endfunction

    // memory lookup shared by read and peek, 0 when unmapped
    function bit lookup(logic [15:0] a, output logic [7:0] b);
      b = '0;
      if (a[15]) begin
        b = rom[rom_offset(a)];
        return 1'b1;
      end
      case (a[15:13])
        cbad_pkg::REGION_IRAM: begin
          b = iram[a % cbad_pkg::RamDepth];
          return 1'b1;
        end
        cbad_pkg::REGION_WRAM: begin
          b = wram[(a - WRAM_BASE) % cbad_pkg::WorkRamDepth];
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // bus write, returns the error flag
    function bit store(logic [15:0] a, logic [7:0] d);
      if (a[15]) return 1'b0;
      case (a[15:13])
        cbad_pkg::REGION_IRAM: begin
          iram[a % cbad_pkg::RamDepth] = d;
          return 1'b0;
        end
        cbad_pkg::REGION_PPU: begin
          case (a[2:0])
            cbad_pkg::PPU_REG_CTRL: begin
              nametable = d[1:0];
              pattern = d[4];
              step32 = d[2];
              return |(d & cbad_pkg::CTRL_RESERVED);
            end
            cbad_pkg::PPU_REG_ADDR: begin
              if (low_next) vaddr[7:0] = d;
              else vaddr[13:8] = d[5:0];
              low_next = !low_next;
              return 1'b0;
            end
            default: return 1'b1;
          endcase
        end
        cbad_pkg::REGION_WRAM: begin
          wram[(a - WRAM_BASE) % cbad_pkg::WorkRamDepth] = d;
          return 1'b0;
        end
        default: return 1'b1;
      endcase
    endfunction

    // one bus operation, returns the response it produces
    function cbad_pkg::rsp_t decode_access(cbad_pkg::req_t r);
      cbad_pkg::rsp_t o;
      logic [7:0] b;
      bit hit;
      o = '0;
      case (r.opcode)
        cbad_pkg::OP_READ: begin
          if (r.bus_address == cbad_pkg::STATUS_ADDR) begin
            o.read_data = status;
            status = status & cbad_pkg::STATUS_CLEAR_MASK;
          end else begin
            hit = lookup(r.bus_address, b);
            o.read_data = b;
            o.bus_error = !hit;
          end
        end
        cbad_pkg::OP_PEEK: begin
          hit = lookup(r.bus_address, b);
          o.read_data = b;
          o.bus_error = !hit;
        end
        cbad_pkg::OP_WRITE: o.bus_error = store(r.bus_address, r.bus_data);
        cbad_pkg::OP_STATUS_LOAD: status = r.bus_data;
        cbad_pkg::OP_ROM_LOAD: begin
          if (r.bus_address < cbad_pkg::RomDepth) begin
            rom[r.bus_address[14:0]] = r.bus_data;
            rom_loaded[r.bus_address[14:0]] = 1'b1;
          end else begin
            o.bus_error = 1'b1;
          end
        end
        default: o.bus_error = 1'b1;
      endcase
      o.vram_address = vaddr;
      o.nametable_select = nametable;
      o.pattern_select = pattern;
      o.increment_32 = step32;
      return o;
    endfunction

    function void note_request(cbad_pkg::req_t r);
      predicted_rsp.push_back(decode_access(r));
    endfunction

    // compare one response with the oldest prediction
    function void check_response(cbad_pkg::rsp_t got);
      cbad_pkg::rsp_t exp;
      if (predicted_rsp.size() == 0) begin
        if (mismatches < 10) $display("response with no request pending: %p", got);
        mismatches++;
        return;
      end
      exp = predicted_rsp.pop_front();
      if (got.read_data !== exp.read_data || got.bus_error !== exp.bus_error ||
          got.vram_address !== exp.vram_address ||
          got.nametable_select !== exp.nametable_select ||
          got.pattern_select !== exp.pattern_select ||
          got.increment_32 !== exp.increment_32) begin
        if (mismatches < 10) begin
          $display("response mismatch: expected rd=%h err=%b vram=%h nt=%0d pat=%b inc32=%b",
                   exp.read_data, exp.bus_error, exp.vram_address, exp.nametable_select,
                   exp.pattern_select, exp.increment_32);
          $display("                   got      rd=%h err=%b vram=%h nt=%0d pat=%b inc32=%b",
                   got.read_data, got.bus_error, got.vram_address, got.nametable_select,
                   got.pattern_select, got.increment_32);
        end
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/cpu_bus_address_decoder_top_tb.sv -----
// testbench top for the cpu bus address decoder
module cpu_bus_address_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int         PhaseItems      = 380;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  cbad_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  cbad_pkg::rsp_t rsp;
  logic cfg_write_enable;
  logic cfg_write_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  cbad_tb_pkg::bus_map_scoreboard sb = new();

  cpu_bus_address_decoder_top #(
    .WORK_RAM_DEPTH(cbad_pkg::WorkRamDepth)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .rsp              (rsp),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // response side: check at the rising edge, pick the stall at the falling edge
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
      @(negedge clk);
      rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic cbad_pkg::req_t make_request(logic [2:0] op, logic [15:0] a,
                                                  logic [7:0] d);
    cbad_pkg::req_t r;
    r.opcode = op;
    r.bus_address = a;
    r.bus_data = d;
    return r;
  endfunction

  // drive one request and hold it until accepted; entered and left at a falling edge
  task automatic send_request(input cbad_pkg::req_t r);
    // never read an image byte that was not loaded
    if ((r.opcode == cbad_pkg::OP_READ || r.opcode == cbad_pkg::OP_PEEK) &&
        !sb.rom_readable(r.bus_address))
      r.bus_address[15] = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every predicted response has arrived
  task automatic wait_drained();
    req_valid = 1'b0;
    while (sb.predicted_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_rom_mirror(input logic v);
    wait_drained();
    cfg_write_enable = 1'b1;
    cfg_write_data = v;
    @(negedge clk);
    cfg_write_enable = 1'b0;
    sb.half_mirror = v;
  endtask

  // field extremes and the special cases of the memory map
  task automatic run_directed();
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h07FF, 8'hFF));
    send_request(make_request(cbad_pkg::OP_READ, 16'h1FFF, 8'h00));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h7FFF, 8'hA5));
    send_request(make_request(cbad_pkg::OP_READ, 16'h7FFF, 8'h00));
    send_request(make_request(cbad_pkg::OP_ROM_LOAD, 16'h0000, 8'h11));
    send_request(make_request(cbad_pkg::OP_ROM_LOAD, 16'h7FFF, 8'hEE));
    send_request(make_request(cbad_pkg::OP_ROM_LOAD, 16'h4000, 8'h5A));
    send_request(make_request(cbad_pkg::OP_ROM_LOAD, 16'hFFFF, 8'h00));
    send_request(make_request(cbad_pkg::OP_READ, 16'h8000, 8'h00));
    send_request(make_request(cbad_pkg::OP_READ, 16'hFFFF, 8'h00));
    send_request(make_request(cbad_pkg::OP_PEEK, 16'hC000, 8'h00));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h8000, 8'h55));
    send_request(make_request(cbad_pkg::OP_STATUS_LOAD, 16'h0000, 8'hFF));
    send_request(make_request(cbad_pkg::OP_READ, cbad_pkg::STATUS_ADDR, 8'h00));
    send_request(make_request(cbad_pkg::OP_READ, cbad_pkg::STATUS_ADDR, 8'h00));
    send_request(make_request(cbad_pkg::OP_PEEK, cbad_pkg::STATUS_ADDR, 8'h00));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h2000, 8'hFF));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h3FF8, 8'h00));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h2006, 8'hFF));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h3FFE, 8'hFF));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h2007, 8'h12));
    send_request(make_request(cbad_pkg::OP_WRITE, 16'h4014, 8'h00));
    send_request(make_request(cbad_pkg::OP_READ, 16'h5FFF, 8'h00));
    send_request(make_request(OP_UNUSED_FIRST, 16'h0000, 8'h00));
    send_request(make_request(OP_UNUSED_LAST, 16'hFFFF, 8'hFF));
  endtask

  // mostly well-formed access sequences with random content, plus noise
  task automatic run_random(input int count);
    int target;
    int kind;
    int n;
    logic [15:0] a;
    logic [15:0] mirror_addr;
    logic [14:0] roff;
    logic [14:0] o;
    logic [7:0] d;
    logic [2:0] op;
    target = requests_sent + count;
    while (requests_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // load a short run of image bytes, then read it back
        roff = 15'($urandom);
        if (sb.half_mirror && $urandom_range(0, 3) != 0) roff[14] = 1'b0;
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++)
          send_request(make_request(cbad_pkg::OP_ROM_LOAD, {1'b0, roff + 15'(i)},
                                    8'($urandom)));
        for (int i = 0; i < n; i++) begin
          o = roff + 15'(i);
          if (!(sb.half_mirror && o[14])) begin
            a = {1'b1, o};
            if (sb.half_mirror && $urandom_range(0, 1)) a[14] = 1'b1;
            op = $urandom_range(0, 1) ? cbad_pkg::OP_READ : cbad_pkg::OP_PEEK;
            send_request(make_request(op, a, 8'($urandom)));
          end
        end
      end else if (kind < 35) begin
        // ram write then read back, internal ram through its mirrors
        a = {($urandom_range(0, 1) ? cbad_pkg::REGION_IRAM : cbad_pkg::REGION_WRAM),
             13'($urandom)};
        send_request(make_request(cbad_pkg::OP_WRITE, a, 8'($urandom)));
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
          mirror_addr = a;
          if (a[15:13] == cbad_pkg::REGION_IRAM) mirror_addr[12:11] = 2'($urandom);
          op = $urandom_range(0, 1) ? cbad_pkg::OP_READ : cbad_pkg::OP_PEEK;
          send_request(make_request(op, mirror_addr, 8'($urandom)));
        end
      end else if (kind < 50) begin
        // vram address pair, sometimes left half written
        a = {cbad_pkg::REGION_PPU, 13'($urandom)};
        a[2:0] = cbad_pkg::PPU_REG_ADDR;
        send_request(make_request(cbad_pkg::OP_WRITE, a, 8'($urandom)));
        if ($urandom_range(0, 6) != 0) begin
          a[12:3] = 10'($urandom);
          send_request(make_request(cbad_pkg::OP_WRITE, a, 8'($urandom)));
        end
      end else if (kind < 60) begin
        // control write, half of them with reserved bits clear
        a = {cbad_pkg::REGION_PPU, 13'($urandom)};
        a[2:0] = cbad_pkg::PPU_REG_CTRL;
        d = 8'($urandom);
        if ($urandom_range(0, 1)) d = d & ~cbad_pkg::CTRL_RESERVED;
        send_request(make_request(cbad_pkg::OP_WRITE, a, d));
      end else if (kind < 70) begin
        // status load then reads that clear its top bit
        send_request(make_request(cbad_pkg::OP_STATUS_LOAD, 16'($urandom), 8'($urandom)));
        send_request(make_request(cbad_pkg::OP_READ, cbad_pkg::STATUS_ADDR, 8'($urandom)));
        if ($urandom_range(0, 1))
          send_request(make_request(cbad_pkg::OP_READ, cbad_pkg::STATUS_ADDR,
                                    8'($urandom)));
        if ($urandom_range(0, 1))
          send_request(make_request(cbad_pkg::OP_PEEK, cbad_pkg::STATUS_ADDR,
                                    8'($urandom)));
      end else if (kind < 78) begin
        // register and io space accesses
        a = {($urandom_range(0, 1) ? cbad_pkg::REGION_PPU : cbad_pkg::REGION_IO),
             13'($urandom)};
        op = 3'($urandom_range(cbad_pkg::OP_READ, cbad_pkg::OP_WRITE));
        send_request(make_request(op, a, 8'($urandom)));
      end else begin
        // anything at all
        op = 3'($urandom_range(cbad_pkg::OP_READ, OP_UNUSED_LAST));
        send_request(make_request(op, 16'($urandom), 8'($urandom)));
      end
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_write_enable = 1'b0;
    cfg_write_data = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // ram clearing pass holds the request side off
    do @(posedge clk); while (req_stall);
    @(negedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 78;
    write_rom_mirror(1'b0);
    run_directed();
    write_rom_mirror(1'b1);
    run_random(PhaseItems);

    send_idle_pct = 78;
    recv_idle_pct = 29;
    write_rom_mirror(1'b0);
    run_random(PhaseItems);
    write_rom_mirror(1'b1);
    run_random(PhaseItems);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rom_mirror(1'b0);
    run_random(PhaseItems);
    write_rom_mirror(1'b1);
    run_random(PhaseItems);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.predicted_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
